### rtl/core/wlqe_pkg.sv
// Shared types, constants and helpers for the wide line quad expander.
package wlqe_pkg;

  localparam logic [15:0] TolReset = 16'd1;
  localparam int unsigned TolShift = 14;
  localparam logic [2:0] LastBeat = 3'd5;

  typedef struct packed {
    logic [2:0][31:0] bgn;
    logic [2:0][31:0] fin;
    logic [3:0][15:0] col;
    logic [30:0]      wid;
    logic             bat;
    logic             deg;
  } line_t;

  function automatic logic [1:0] corner_of(input logic [2:0] beat);
    logic [1:0] c;
    case (beat)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/wlqe_norm.sv
// Pipelined 3-vector normalizer to Q2.30: shift, squares, root steps, divide steps.
module wlqe_norm #(
  parameter int PayW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  vld_i,
  input  logic [2:0][63:0]      vec_i,
  input  logic [PayW-1:0]       pay_i,
  output logic                  vld_o,
  output logic [2:0][31:0]      unit_o,
  output logic [PayW-1:0]       pay_o
);

  localparam int SqSteps  = 31;
  localparam int DivSteps = 31;
  localparam int Lat      = 5 + SqSteps + DivSteps;
  localparam int SdW      = PayW + 3;

  logic            vld_q [Lat];
  logic [SdW-1:0]  sd_q  [Lat];

  logic [2:0]      neg_in;
  logic [62:0]     mag_in [3];

  logic [62:0]     mag_a_q [3];
  logic [62:0]     mag_b_q [3];
  logic [5:0]      pos_b_q;
  logic [5:0]      pos_d;
  logic [62:0]     or_a;
  logic [62:0]     shv [3];
  logic [29:0]     m_c_q [3];
  logic [29:0]     m_d_q [3];
  logic [59:0]     sq_d_q [3];

  logic [29:0]     m_s_q [SqSteps+1][3];
  logic [62:0]     n_s_q [SqSteps+1];
  logic [62:0]     r_s_q [SqSteps+1];

  logic [30:0]     len_v_q [DivSteps];
  logic [30:0]     rem_v_q [DivSteps][3];
  logic [30:0]     quo_v_q [DivSteps][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = vec_i[i][63];
      mag_in[i] = neg_in[i] ? 63'(~vec_i[i] + 64'd1) : vec_i[i][62:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lat; k++) vld_q[k] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < Lat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sd_q[0] <= {neg_in, pay_i};
      for (int k = 1; k < Lat; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  always_comb begin
    or_a  = mag_a_q[0] | mag_a_q[1] | mag_a_q[2];
    pos_d = '0;
    for (int k = 0; k < 63; k++) begin
      if (or_a[k]) pos_d = 6'(k);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_b_q >= 6'd29) begin
        shv[i] = mag_b_q[i] >> (pos_b_q - 6'd29);
      end else begin
        shv[i] = mag_b_q[i] << (6'd29 - pos_b_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        mag_a_q[i]  <= mag_in[i];
        mag_b_q[i]  <= mag_a_q[i];
        m_c_q[i]    <= shv[i][29:0];
        m_d_q[i]    <= m_c_q[i];
        sq_d_q[i]   <= {30'b0, m_c_q[i]} * {30'b0, m_c_q[i]};
        m_s_q[0][i] <= m_d_q[i];
      end
      pos_b_q  <= pos_d;
      n_s_q[0] <= 63'(sq_d_q[0]) + 63'(sq_d_q[1]) + 63'(sq_d_q[2]);
      r_s_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= SqSteps; k++) begin : g_root
    localparam logic [62:0] Bit = 63'(1) << (2 * (SqSteps - k));
    logic [62:0] trial;
    assign trial = r_s_q[k-1] + Bit;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (n_s_q[k-1] >= trial) begin
          n_s_q[k] <= n_s_q[k-1] - trial;
          r_s_q[k] <= (r_s_q[k-1] >> 1) + Bit;
        end else begin
          n_s_q[k] <= n_s_q[k-1];
          r_s_q[k] <= r_s_q[k-1] >> 1;
        end
        m_s_q[k] <= m_s_q[k-1];
      end
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [30:0] lp;
    if (j == 0) begin : g_first
      assign lp = r_s_q[SqSteps][30:0];
    end else begin : g_next
      assign lp = len_v_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) len_v_q[j] <= lp;
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [31:0] t;
      logic        ge;
      logic [29:0] qp;
      if (j == 0) begin : g_first
        assign t  = {2'b0, m_s_q[SqSteps][i][29:1], m_s_q[SqSteps][i][0]};
        assign qp = '0;
      end else begin : g_next
        assign t  = {rem_v_q[j-1][i], 1'b0};
        assign qp = quo_v_q[j-1][i][29:0];
      end
      assign ge = t >= {1'b0, lp};
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_v_q[j][i] <= ge ? 31'(t - {1'b0, lp}) : t[30:0];
          quo_v_q[j][i] <= {qp, ge};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = sd_q[Lat-1][PayW+i] ? 32'(-{1'b0, quo_v_q[DivSteps-1][i]})
                                      : {1'b0, quo_v_q[DivSteps-1][i]};
    end
  end

  assign vld_o = vld_q[Lat-1];
  assign pay_o = sd_q[Lat-1][PayW-1:0];

endmodule

### rtl/core/wide_line_quad_expander.sv
// Top level: expands a wide view-space line into two triangles (six vertex beats).
//
//   channel | signals                     | dir | beat
//   --------+-----------------------------+-----+-------------------------------
//   in      | in_valid_i / in_ready_o     | in  | one line segment
//   out     | out_valid_o / out_ready_i   | out | one vertex or a batch-end marker
//   cfg     | cfg_we_i / cfg_wdata_i      | in  | flat_tolerance write
//
// Two normalizer pipelines of 67 stages each dominate the latency from input
// beat to first vertex. The single output port sets the throughput (six beats
// per line, one for a marker, none for a dropped degenerate line); the
// pipeline holds until the last beat of a line is taken. Reset clears all
// valid bits and sets the tolerance to 1. A stalled output freezes the whole
// pipeline; the input register still takes a beat while empty.
module wide_line_quad_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] begin_x_i,
  input  logic [31:0] begin_y_i,
  input  logic [31:0] begin_z_i,
  input  logic [31:0] end_x_i,
  input  logic [31:0] end_y_i,
  input  logic [31:0] end_z_i,
  input  logic [15:0] color_r_i,
  input  logic [15:0] color_g_i,
  input  logic [15:0] color_b_i,
  input  logic [15:0] color_a_i,
  input  logic [30:0] line_width_i,
  input  logic        batch_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] vertex_x_o,
  output logic [31:0] vertex_y_o,
  output logic [31:0] vertex_z_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic [15:0] out_alpha_o,
  output logic        vertex_valid_o,
  output logic        last_of_line_o,
  output logic        last_of_batch_o
);

  localparam int PayW = $bits(wlqe_pkg::line_t);

  logic                  adv;
  logic [15:0]           tol_q;

  logic                  t0_vld_q;
  wlqe_pkg::line_t       t0_q;
  logic [2:0][63:0]      vec1;
  logic [2:0]            dz;

  logic                  n1_vld;
  logic [2:0][31:0]      n1_u;
  logic [PayW-1:0]       n1_pay;
  wlqe_pkg::line_t       n1_ln;

  logic                  x1_vld_q, x2_vld_q, x3_vld_q;
  logic [2:0][31:0]      x1_u_q, x2_u_q, x3_u_q;
  logic [2:0][31:0]      x1_mid_q;
  wlqe_pkg::line_t       x1_ln_q, x2_ln_q, x3_ln_q;
  logic signed [63:0]    x2_p_q [6];
  logic                  x2_flat_q, x3_flat_q;
  logic signed [63:0]    x3_s_q [3];
  logic [2:0][31:0]      mid_d;
  logic [31:0]           u2_mag;
  logic [31:0]           nu1;
  logic                  fb;
  logic [2:0][63:0]      vec2;

  logic                  n2_vld;
  logic [2:0][31:0]      n2_u;
  logic [PayW-1:0]       n2_pay;

  logic                  y1_vld_q, y2_vld_q, y3_vld_q;
  logic [2:0][31:0]      y1_s_q;
  wlqe_pkg::line_t       y1_ln_q, y2_ln_q, y3_ln_q;
  logic [61:0]           y2_p_q [3];
  logic [2:0]            y2_neg_q;
  logic signed [32:0]    y3_off_q [3];
  logic [30:0]           s_mag [3];
  logic [62:0]           rnd [3];

  logic                  em_vld_q;
  logic [2:0]            cnt_q;
  logic [3:0][2:0][31:0] em_c_q;
  logic [3:0][15:0]      em_col_q;
  logic                  em_bat_q;
  logic                  em_deg_q;
  logic [3:0][2:0][31:0] cor_d;
  logic [1:0]            csel;
  logic                  last_beat;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= wlqe_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // input register
  assign in_ready_o = adv || !t0_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      t0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      t0_q.bgn <= {begin_z_i, begin_y_i, begin_x_i};
      t0_q.fin <= {end_z_i, end_y_i, end_x_i};
      t0_q.col <= {color_a_i, color_b_i, color_g_i, color_r_i};
      t0_q.wid <= line_width_i;
      t0_q.bat <= batch_end_i;
      t0_q.deg <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [32:0] d;
      d       = {t0_q.fin[i][31], t0_q.fin[i]} - {t0_q.bgn[i][31], t0_q.bgn[i]};
      dz[i]   = (d == 33'd0);
      vec1[i] = {{31{d[32]}}, d};
    end
  end

  wlqe_norm #(.PayW(PayW)) u_norm_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (t0_vld_q),
    .vec_i  (vec1),
    .pay_i  ({t0_q[PayW-1:1], &dz}),
    .vld_o  (n1_vld),
    .unit_o (n1_u),
    .pay_o  (n1_pay)
  );

  assign n1_ln = n1_pay;

  // side vector: cross(u, mid) with fallback
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [32:0] sm;
      sm       = {n1_ln.bgn[i][31], n1_ln.bgn[i]} + {n1_ln.fin[i][31], n1_ln.fin[i]};
      mid_d[i] = sm[32:1];
    end
    u2_mag = x1_u_q[2][31] ? 32'(-x1_u_q[2]) : x1_u_q[2];
    nu1    = 32'(-x3_u_q[1]);
    fb     = x3_flat_q || ((x3_s_q[0] == 64'sd0) && (x3_s_q[1] == 64'sd0)
                           && (x3_s_q[2] == 64'sd0));
    if (fb) begin
      vec2[0] = {{32{nu1[31]}}, nu1};
      vec2[1] = {{32{x3_u_q[0][31]}}, x3_u_q[0]};
      vec2[2] = {{32{x3_u_q[2][31]}}, x3_u_q[2]};
    end else begin
      vec2[0] = x3_s_q[0];
      vec2[1] = x3_s_q[1];
      vec2[2] = x3_s_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
      x3_vld_q <= 1'b0;
      y1_vld_q <= 1'b0;
      y2_vld_q <= 1'b0;
      y3_vld_q <= 1'b0;
    end else if (adv) begin
      x1_vld_q <= n1_vld;
      x2_vld_q <= x1_vld_q;
      x3_vld_q <= x2_vld_q;
      y1_vld_q <= n2_vld;
      y2_vld_q <= y1_vld_q;
      y3_vld_q <= y2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_u_q    <= n1_u;
      x1_mid_q  <= mid_d;
      x1_ln_q   <= n1_ln;
      x2_p_q[0] <= $signed(x1_u_q[1]) * $signed(x1_mid_q[2]);
      x2_p_q[1] <= $signed(x1_u_q[2]) * $signed(x1_mid_q[1]);
      x2_p_q[2] <= $signed(x1_u_q[2]) * $signed(x1_mid_q[0]);
      x2_p_q[3] <= $signed(x1_u_q[0]) * $signed(x1_mid_q[2]);
      x2_p_q[4] <= $signed(x1_u_q[0]) * $signed(x1_mid_q[1]);
      x2_p_q[5] <= $signed(x1_u_q[1]) * $signed(x1_mid_q[0]);
      x2_flat_q <= u2_mag <= {2'b0, tol_q, {wlqe_pkg::TolShift{1'b0}}};
      x2_u_q    <= x1_u_q;
      x2_ln_q   <= x1_ln_q;
      x3_s_q[0] <= x2_p_q[0] - x2_p_q[1];
      x3_s_q[1] <= x2_p_q[2] - x2_p_q[3];
      x3_s_q[2] <= x2_p_q[4] - x2_p_q[5];
      x3_flat_q <= x2_flat_q;
      x3_u_q    <= x2_u_q;
      x3_ln_q   <= x2_ln_q;
    end
  end

  wlqe_norm #(.PayW(PayW)) u_norm_side (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (x3_vld_q),
    .vec_i  (vec2),
    .pay_i  (x3_ln_q),
    .vld_o  (n2_vld),
    .unit_o (n2_u),
    .pay_o  (n2_pay)
  );

  // offset = side * width / 2, rounded half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_mag[i] = y1_s_q[i][31] ? 31'(-y1_s_q[i]) : y1_s_q[i][30:0];
      rnd[i]   = {1'b0, y2_p_q[i]} + (63'(1) << 30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y1_s_q  <= n2_u;
      y1_ln_q <= n2_pay;
      for (int i = 0; i < 3; i++) begin
        y2_p_q[i]   <= {31'b0, s_mag[i]} * {31'b0, y1_ln_q.wid};
        y2_neg_q[i] <= y1_s_q[i][31];
        y3_off_q[i] <= y2_neg_q[i] ? -$signed({1'b0, rnd[i][62:31]})
                                   : $signed({1'b0, rnd[i][62:31]});
      end
      y2_ln_q <= y1_ln_q;
      y3_ln_q <= y2_ln_q;
    end
  end

  // corners
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [33:0] b, e, o;
      b = $signed({{2{y3_ln_q.bgn[i][31]}}, y3_ln_q.bgn[i]});
      e = $signed({{2{y3_ln_q.fin[i][31]}}, y3_ln_q.fin[i]});
      o = $signed({y3_off_q[i][32], y3_off_q[i]});
      cor_d[0][i] = wlqe_pkg::sat32(b + o);
      cor_d[1][i] = wlqe_pkg::sat32(b - o);
      cor_d[2][i] = wlqe_pkg::sat32(e - o);
      cor_d[3][i] = wlqe_pkg::sat32(e + o);
    end
  end

  // vertex emitter
  assign last_beat = em_deg_q || (cnt_q == wlqe_pkg::LastBeat);
  assign adv       = !em_vld_q || (out_ready_i && last_beat);
  assign csel      = wlqe_pkg::corner_of(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else if (adv) begin
      em_vld_q <= y3_vld_q && (!y3_ln_q.deg || y3_ln_q.bat);
      cnt_q    <= '0;
    end else if (out_ready_i) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      em_c_q   <= cor_d;
      em_col_q <= y3_ln_q.col;
      em_bat_q <= y3_ln_q.bat;
      em_deg_q <= y3_ln_q.deg;
    end
  end

  assign out_valid_o     = em_vld_q;
  assign vertex_x_o      = em_deg_q ? 32'd0 : em_c_q[csel][0];
  assign vertex_y_o      = em_deg_q ? 32'd0 : em_c_q[csel][1];
  assign vertex_z_o      = em_deg_q ? 32'd0 : em_c_q[csel][2];
  assign out_red_o       = em_col_q[0];
  assign out_green_o     = em_col_q[1];
  assign out_blue_o      = em_col_q[2];
  assign out_alpha_o     = em_col_q[3];
  assign vertex_valid_o  = !em_deg_q;
  assign last_of_line_o  = last_beat;
  assign last_of_batch_o = last_beat && em_bat_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_vld_q |-> (cnt_q <= wlqe_pkg::LastBeat))
    else $error("beat counter past last corner");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !vertex_valid_o) |-> (last_of_line_o && last_of_batch_o))
    else $error("marker beat without end flags");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(cnt_q)))
    else $error("stalled beat lost");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (em_vld_q && !last_beat) |-> !adv)
    else $error("pipeline advanced mid line");

endmodule
